[design/size_class_free_list_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core_assert.svh
// Assertion macros for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SCFLA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfla assertion failed");

// Condition must never be seen outside reset.
`define SCFLA_ASSERT_NEVER(label, clk, rst_n, cond) \
    `SCFLA_ASSERT(label, clk, rst_n, !(cond))

`endif

[design/scfla_pkg.sv]
// ----------------------------------------------------------------------------
// scfla_pkg
// Types, codes and defaults for the size class free list allocator.
// ----------------------------------------------------------------------------
package scfla_pkg;

    localparam int MEM_WORDS_DEF   = 65536;
    localparam int BLOCK_WORDS_DEF = 4096;
    localparam int NUM_CLASSES_DEF = 16;
    localparam int WORD_BYTES_DEF  = 8;

    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;

    // Size-to-class reciprocal: managed sizes minus one stay below 2**CLS_X_W.
    localparam int CLS_X_W     = 10;
    localparam int RECIP_SHIFT = 16;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_MANAGED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_MEMORY   = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   chunk_address;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_LINK,
        S_CARVE,
        S_DONE
    } state_t;

endpackage

[design/scfla_ram.sv]
// ----------------------------------------------------------------------------
// scfla_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module scfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/size_class_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core
// Segregated-fit allocator: per-class LIFO free lists over a word memory.
// ----------------------------------------------------------------------------
// Requests come in on req_valid/req_ready with a req_t payload (allocate or
// free, byte size, free address); one response per request leaves on
// rsp_valid/rsp_ready as an rsp_t (chunk address, status).
// One request is worked at a time. Steps from the accepting edge (head RAM
// read) to the registered response:
//   free or unmanaged size        head read, response registered
//   allocate from a nonempty list head read, then link read
//   allocate that carves a block  head read, then one link write per chunk
//                                 after the first; chunk 0 goes straight out
//   allocate with no memory left  head read, response registered
// req_ready is high again from the edge that registers the response, so a
// new request is taken only once the last response has been registered.
// The response sits in an output register; if the receiver stalls, the next
// request can still be taken and worked, and its result waits in a holding
// register until the output frees up.
// Reset empties all class lists (per-class valid bits) and zeroes the carve
// pointer at once; there is no clearing pass. Link RAM content is never read
// before it is written.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core #(
    parameter int MEM_WORDS   = scfla_pkg::MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = scfla_pkg::BLOCK_WORDS_DEF,
    parameter int NUM_CLASSES = scfla_pkg::NUM_CLASSES_DEF,
    parameter int WORD_BYTES  = scfla_pkg::WORD_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  scfla_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output scfla_pkg::rsp_t  rsp
);

    localparam int AW    = $clog2(MEM_WORDS);
    localparam int PW    = AW + 1;
    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int NW    = $clog2(BLOCK_WORDS + 1);
    localparam int SUMW  = ((PW > NW) ? PW : NW) + 1;
    localparam int RECIP = ((1 << scfla_pkg::RECIP_SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RW    = scfla_pkg::RECIP_SHIFT + 1;
    localparam int PRW   = scfla_pkg::CLS_X_W + RW;
    localparam int MAX_SIZE = (NUM_CLASSES - 1) * WORD_BYTES;
    localparam logic [PW-1:0] EMPTY = {1'b1, {AW{1'b0}}};

    // Per-class chunk count and span of a fresh block
    logic [NW-1:0] nch_tab  [NUM_CLASSES];
    logic [NW-1:0] span_tab [NUM_CLASSES];

    for (genvar k = 0; k < NUM_CLASSES; k++)
    begin : g_tab
        localparam int NCH  = BLOCK_WORDS / ((k == 0) ? 1 : k);
        localparam int SPAN = NCH * k;
        assign nch_tab[k]  = NW'(NCH);
        assign span_tab[k] = NW'(SPAN);
    end

    scfla_pkg::state_t state_reg, state_next;

    logic                  kind_reg;
    logic [CW-1:0]         cls_reg;
    logic                  managed_reg;
    logic                  faddr_ok_reg;
    logic [AW-1:0]         faddr_reg;
    logic [PW-1:0]         cp_reg, cp_next;
    logic [AW-1:0]         head_addr_reg, head_addr_next;
    logic [PW-1:0]         walk_reg, walk_next;
    logic [NW-1:0]         remain_reg, remain_next;
    logic [NUM_CLASSES-1:0] head_vld_reg;
    logic                  hv_rd_reg;
    logic                  rsp_valid_reg;
    scfla_pkg::rsp_t       rsp_reg;
    scfla_pkg::rsp_t       res_reg;

    // Size decode
    logic                  managed_in;
    logic                  faddr_ok_in;
    logic [scfla_pkg::SIZE_W-1:0] size_m1;
    logic [PRW-1:0]        prod;
    logic [CW-1:0]         cls_in;

    // RAM ports
    logic                  h_we, h_re;
    logic [CW-1:0]         h_waddr, h_raddr;
    logic [PW-1:0]         h_wdata, h_rdata;
    logic                  l_we, l_re;
    logic [AW-1:0]         l_waddr, l_raddr;
    logic [PW-1:0]         l_wdata, l_rdata;

    logic [PW-1:0]         head_cur;
    logic                  head_empty;
    logic [PW-1:0]         cls_ext;
    logic [NW-1:0]         nch_cur, span_cur;
    logic                  fits;
    logic                  slot_free;
    logic                  fin;
    scfla_pkg::rsp_t       fin_data;
    logic                  rsp_load;

    assign size_m1     = req.size_bytes - scfla_pkg::SIZE_W'(1);
    assign prod        = PRW'(size_m1[scfla_pkg::CLS_X_W-1:0]) * PRW'(RECIP);
    assign cls_in      = CW'(prod[PRW-1:scfla_pkg::RECIP_SHIFT]) + CW'(1);
    assign managed_in  = (req.size_bytes != '0) && (32'(req.size_bytes) <= 32'(MAX_SIZE));
    assign faddr_ok_in = 32'(req.free_address) < 32'(MEM_WORDS);

    assign head_cur   = hv_rd_reg ? h_rdata : EMPTY;
    assign head_empty = head_cur[AW];
    assign cls_ext    = PW'(cls_reg);
    assign nch_cur    = nch_tab[cls_reg];
    assign span_cur   = span_tab[cls_reg];
    assign fits       = (SUMW'(cp_reg) + SUMW'(span_cur)) <= SUMW'(MEM_WORDS);
    assign slot_free  = !rsp_valid_reg || rsp_ready;

    scfla_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_CLASSES)
    ) u_head_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    scfla_ram #(
        .WIDTH (PW),
        .DEPTH (MEM_WORDS)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = (state_reg == scfla_pkg::S_IDLE);
        h_we           = 1'b0;
        h_waddr        = cls_reg;
        h_wdata        = EMPTY;
        h_re           = 1'b0;
        h_raddr        = managed_in ? cls_in : '0;
        l_we           = 1'b0;
        l_waddr        = faddr_reg;
        l_wdata        = head_cur;
        l_re           = 1'b0;
        l_raddr        = head_cur[AW-1:0];
        cp_next        = cp_reg;
        walk_next      = walk_reg;
        remain_next    = remain_reg;
        head_addr_next = head_addr_reg;
        fin            = 1'b0;
        fin_data       = '0;

        unique case (state_reg)
            scfla_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    h_re       = 1'b1;
                    state_next = scfla_pkg::S_HEAD;
                end
            end
            scfla_pkg::S_HEAD:
            begin
                priority if (!managed_reg || (kind_reg == scfla_pkg::KIND_FREE && !faddr_ok_reg))
                begin
                    fin             = 1'b1;
                    fin_data.status = scfla_pkg::STAT_NOT_MANAGED;
                end
                else if (kind_reg == scfla_pkg::KIND_FREE)
                begin
                    // push: link the old head behind the freed chunk
                    l_we            = 1'b1;
                    h_we            = 1'b1;
                    h_wdata         = {1'b0, faddr_reg};
                    fin             = 1'b1;
                    fin_data.status = scfla_pkg::STAT_OK;
                end
                else if (!head_empty)
                begin
                    l_re           = 1'b1;
                    head_addr_next = head_cur[AW-1:0];
                    state_next     = scfla_pkg::S_LINK;
                end
                else if (nch_cur == '0 || !fits)
                begin
                    fin             = 1'b1;
                    fin_data.status = scfla_pkg::STAT_NO_MEMORY;
                end
                else if (nch_cur == NW'(1))
                begin
                    // single-chunk block: hand it out, list stays empty
                    h_we                   = 1'b1;
                    h_wdata                = EMPTY;
                    cp_next                = cp_reg + PW'(span_cur);
                    fin                    = 1'b1;
                    fin_data.chunk_address = scfla_pkg::ADDR_W'(cp_reg);
                    fin_data.status        = scfla_pkg::STAT_OK;
                end
                else
                begin
                    walk_next   = cp_reg + cls_ext;
                    remain_next = nch_cur - NW'(1);
                    state_next  = scfla_pkg::S_CARVE;
                end
            end
            scfla_pkg::S_LINK:
            begin
                h_we                   = 1'b1;
                h_wdata                = l_rdata;
                fin                    = 1'b1;
                fin_data.chunk_address = scfla_pkg::ADDR_W'(head_addr_reg);
                fin_data.status        = scfla_pkg::STAT_OK;
            end
            scfla_pkg::S_CARVE:
            begin
                // link chunks 1..n-1; chunk 0 goes straight out
                l_we        = 1'b1;
                l_waddr     = walk_reg[AW-1:0];
                l_wdata     = (remain_reg == NW'(1)) ? EMPTY : walk_reg + cls_ext;
                walk_next   = walk_reg + cls_ext;
                remain_next = remain_reg - NW'(1);
                if (remain_reg == NW'(1))
                begin
                    h_we                   = 1'b1;
                    h_wdata                = cp_reg + cls_ext;
                    cp_next                = cp_reg + PW'(span_cur);
                    fin                    = 1'b1;
                    fin_data.chunk_address = scfla_pkg::ADDR_W'(cp_reg);
                    fin_data.status        = scfla_pkg::STAT_OK;
                end
            end
            scfla_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = scfla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scfla_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = slot_free ? scfla_pkg::S_IDLE : scfla_pkg::S_DONE;
        end
    end

    assign rsp_load = (fin || state_reg == scfla_pkg::S_DONE) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scfla_pkg::S_IDLE;
            cp_reg        <= '0;
            head_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cp_reg        <= cp_next;
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && !rsp_ready);
            if (h_we)
            begin
                head_vld_reg[h_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_addr_reg <= head_addr_next;
        walk_reg      <= walk_next;
        remain_reg    <= remain_next;
        if (h_re)
        begin
            hv_rd_reg    <= head_vld_reg[h_raddr];
            kind_reg     <= req.kind;
            cls_reg      <= cls_in;
            managed_reg  <= managed_in;
            faddr_ok_reg <= faddr_ok_in;
            faddr_reg    <= AW'(req.free_address);
        end
        if (rsp_load)
        begin
            rsp_reg <= (state_reg == scfla_pkg::S_DONE) ? res_reg : fin_data;
        end
        if (fin && !slot_free)
        begin
            res_reg <= fin_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/scfla_checker.sv]
// ----------------------------------------------------------------------------
// scfla_checker
// Port-level checks for the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
`include "size_class_free_list_allocator_core_assert.svh"

module scfla_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input scfla_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input scfla_pkg::rsp_t rsp
);

    // hold a stalled response
    `SCFLA_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

    `SCFLA_ASSERT(a_status_code, clk, rst_n, rsp_valid |-> rsp.status <= scfla_pkg::STAT_NO_MEMORY)

    `SCFLA_ASSERT_NEVER(a_fail_addr, clk, rst_n, rsp_valid && rsp.status != scfla_pkg::STAT_OK && rsp.chunk_address != '0)

    // one request at a time
    `SCFLA_ASSERT(a_one_inflight, clk, rst_n, req_valid && req_ready |=> !req_ready)

    // a response only appears after the core was busy
    `SCFLA_ASSERT(a_rsp_after_busy, clk, rst_n, $rose(rsp_valid) |-> $past(!req_ready))

endmodule

bind size_class_free_list_allocator_core scfla_checker u_scfla_checker (.*);

[sim/tb_size_class_free_list_allocator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_free_list_allocator_core
// Self-checking bench for the size class free list allocator.
// ----------------------------------------------------------------------------
// Requests are driven on the valid/ready request channel, and a local
// predictor keeps its own copy of the class lists, link words and carve
// pointer. Every accepted request adds one expected response, and responses
// are compared in order. The tests cover directed corner cases, a long
// receiver stall, mixed random traffic with list draining, and memory
// exhaustion. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_size_class_free_list_allocator_core;

    localparam int          CLK_PERIOD       = 20;
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          MAX_MANAGED      = (scfla_pkg::NUM_CLASSES_DEF - 1) *
                                               scfla_pkg::WORD_BYTES_DEF;
    localparam logic [16:0] NULL_LINK        = 17'h10000;

    typedef struct {
        logic [scfla_pkg::ADDR_W-1:0] addr;
        int                           cls;
    } chunk_rec_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    scfla_pkg::req_t req       = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    scfla_pkg::rsp_t rsp;

    // predictor state
    logic [16:0] class_head [scfla_pkg::NUM_CLASSES_DEF];
    logic [16:0] word_link [scfla_pkg::MEM_WORDS_DEF];
    logic [16:0] carve_ptr;

    scfla_pkg::rsp_t expected_responses[$];
    chunk_rec_t      live_chunks[$];

    int  sent_count       = 0;
    int  fail_count       = 0;
    int  cycle_count      = 0;
    int  ok_count         = 0;
    int  not_managed_count = 0;
    int  no_memory_count  = 0;
    int  blocks_carved    = 0;
    logic steady_flow     = 1'b0;
    logic long_hold_req   = 1'b0;

    size_class_free_list_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Work out the response to one accepted request and update the lists.
    function automatic scfla_pkg::rsp_t predict_chunk_response(scfla_pkg::req_t r);
        scfla_pkg::rsp_t res;
        int              cls;
        int              nchunks;
        int              span;
        int              base;
        logic [16:0]     head;
        res.chunk_address = '0;
        res.status        = scfla_pkg::STAT_OK;
        if (r.size_bytes == '0)
            res.status = scfla_pkg::STAT_NOT_MANAGED;
        else
        begin
            cls = (int'(r.size_bytes) - 1) / scfla_pkg::WORD_BYTES_DEF + 1;
            if (cls >= scfla_pkg::NUM_CLASSES_DEF)
                res.status = scfla_pkg::STAT_NOT_MANAGED;
            else if (r.kind == scfla_pkg::KIND_FREE)
            begin
                if (int'(r.free_address) >= scfla_pkg::MEM_WORDS_DEF)
                    res.status = scfla_pkg::STAT_NOT_MANAGED;
                else
                begin
                    word_link[r.free_address] = class_head[cls];
                    class_head[cls]           = {1'b0, r.free_address};
                end
            end
            else
            begin
                if (class_head[cls][16])
                begin
                    nchunks = scfla_pkg::BLOCK_WORDS_DEF / cls;
                    span    = nchunks * cls;
                    if (nchunks > 0 && int'(carve_ptr) + span <= scfla_pkg::MEM_WORDS_DEF)
                    begin
                        base = int'(carve_ptr);
                        // link the new chunks lowest address first
                        for (int k = 0; k < nchunks; k++)
                            word_link[base + k * cls] = (k + 1 < nchunks) ?
                                17'(base + (k + 1) * cls) : NULL_LINK;
                        class_head[cls] = 17'(base);
                        carve_ptr       = 17'(base + span);
                        blocks_carved++;
                    end
                end
                if (class_head[cls][16])
                    res.status = scfla_pkg::STAT_NO_MEMORY;
                else
                begin
                    head              = class_head[cls];
                    res.chunk_address = head[scfla_pkg::ADDR_W-1:0];
                    class_head[cls]   = word_link[head[scfla_pkg::ADDR_W-1:0]];
                end
            end
        end
        case (res.status)
            scfla_pkg::STAT_OK:          ok_count++;
            scfla_pkg::STAT_NOT_MANAGED: not_managed_count++;
            default:                     no_memory_count++;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [scfla_pkg::SIZE_W-1:0] bytes_in_class(int cls);
        return 16'($urandom_range((cls - 1) * scfla_pkg::WORD_BYTES_DEF + 1,
                                  cls * scfla_pkg::WORD_BYTES_DEF));
    endfunction

    function automatic int find_empty_class(int skip);
        int start;
        int c;
        start = $urandom_range(1, scfla_pkg::NUM_CLASSES_DEF - 1);
        for (int k = 0; k < scfla_pkg::NUM_CLASSES_DEF - 1; k++)
        begin
            c = (start - 1 + k) % (scfla_pkg::NUM_CLASSES_DEF - 1) + 1;
            if (c != skip && class_head[c][16])
                return c;
        end
        return 0;
    endfunction

    task automatic send_request(input logic kind,
                                input logic [scfla_pkg::SIZE_W-1:0] size_bytes,
                                input logic [scfla_pkg::ADDR_W-1:0] free_address);
        scfla_pkg::req_t item;
        scfla_pkg::rsp_t want;
        int              gap;
        item.kind         = kind;
        item.size_bytes   = size_bytes;
        item.free_address = free_address;
        gap = (steady_flow || $urandom_range(0, 99) < 70) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        want = predict_chunk_response(item);
        expected_responses.push_back(want);
        sent_count++;
        if (kind == scfla_pkg::KIND_ALLOC && want.status == scfla_pkg::STAT_OK)
            live_chunks.push_back('{addr: want.chunk_address,
                                    cls: (int'(size_bytes) - 1) /
                                         scfla_pkg::WORD_BYTES_DEF + 1});
    endtask

    task automatic do_alloc(input int cls);
        send_request(scfla_pkg::KIND_ALLOC, bytes_in_class(cls),
                     16'($urandom_range(0, 65535)));
    endtask

    task automatic free_chunk(input int cls, input logic [scfla_pkg::ADDR_W-1:0] addr);
        send_request(scfla_pkg::KIND_FREE, bytes_in_class(cls), addr);
    endtask

    task automatic free_live_chunk();
        int         idx;
        chunk_rec_t rec;
        idx = $urandom_range(0, live_chunks.size() - 1);
        rec = live_chunks[idx];
        live_chunks.delete(idx);
        free_chunk(rec.cls, rec.addr);
    endtask

    // Cut a class list short: push its head onto an empty list, which ends the
    // head's link, then pop it from both lists. The next allocate carves.
    task automatic drain_class(input int cls);
        int                           scratch;
        logic [scfla_pkg::ADDR_W-1:0] head_addr;
        scratch = find_empty_class(cls);
        if (scratch == 0 || class_head[cls][16])
            do_alloc(cls);
        else
        begin
            head_addr = class_head[cls][scfla_pkg::ADDR_W-1:0];
            free_chunk(scratch, head_addr);
            do_alloc(cls);
            do_alloc(scratch);
        end
    endtask

    task automatic test_directed_cases();
        send_request(scfla_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);
        send_request(scfla_pkg::KIND_FREE, 16'd0, 16'h0000);
        send_request(scfla_pkg::KIND_ALLOC, 16'(MAX_MANAGED + 1), 16'h0000);
        send_request(scfla_pkg::KIND_FREE, 16'hFFFF, 16'hFFFF);
        send_request(scfla_pkg::KIND_ALLOC, 16'(MAX_MANAGED), 16'h0000);
        send_request(scfla_pkg::KIND_ALLOC,
                     16'(MAX_MANAGED - scfla_pkg::WORD_BYTES_DEF + 1), 16'h0000);
        send_request(scfla_pkg::KIND_FREE, 16'(MAX_MANAGED), 16'h0000);
        send_request(scfla_pkg::KIND_ALLOC, 16'(MAX_MANAGED), 16'h5555);
        send_request(scfla_pkg::KIND_ALLOC, 16'd1, 16'hFFFF);
        send_request(scfla_pkg::KIND_ALLOC, 16'(scfla_pkg::WORD_BYTES_DEF), 16'hAAAA);
        // freed address lands on an empty class list
        send_request(scfla_pkg::KIND_FREE, 16'(2 * scfla_pkg::WORD_BYTES_DEF), 16'hFFFF);
        send_request(scfla_pkg::KIND_ALLOC, 16'(scfla_pkg::WORD_BYTES_DEF + 1), 16'h0000);
        send_request(scfla_pkg::KIND_ALLOC, 16'(2 * scfla_pkg::WORD_BYTES_DEF), 16'h0000);
        // free under a class other than the one it came from
        send_request(scfla_pkg::KIND_FREE, 16'd1, 16'h0000);
        send_request(scfla_pkg::KIND_ALLOC, 16'd2, 16'h0000);
        send_request(scfla_pkg::KIND_FREE, 16'(MAX_MANAGED + 1), 16'h8000);
    endtask

    task automatic test_backpressure();
        steady_flow   = 1'b1;
        long_hold_req = 1'b1;
        repeat (24)
        begin
            if ($urandom_range(0, 1) == 0 && live_chunks.size() > 0)
                free_live_chunk();
            else
                do_alloc($urandom_range(1, 2));
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        int segment;
        int last_segment;
        int roll;
        int c;
        start        = sent_count;
        last_segment = -1;
        while (sent_count - start < target)
        begin
            // alternate stretches with and without idling
            segment = (sent_count - start) / 100;
            if (segment != last_segment)
            begin
                steady_flow  = ($urandom_range(0, 3) == 0);
                last_segment = segment;
            end
            roll = $urandom_range(0, 99);
            c    = $urandom_range(1, scfla_pkg::NUM_CLASSES_DEF - 1);
            if (roll < 45 || (roll < 77 && live_chunks.size() == 0))
                do_alloc(c);
            else if (roll < 77)
                free_live_chunk();
            else if (roll < 86)
                send_request(1'($urandom_range(0, 1)),
                             ($urandom_range(0, 4) == 0) ? 16'd0 :
                                 16'($urandom_range(MAX_MANAGED + 1, 65535)),
                             16'($urandom_range(0, 65535)));
            else if (roll < 92)
                free_chunk(c, 16'($urandom_range(0, 65535)));
            else if (roll < 96 && live_chunks.size() > 0)
                free_chunk(c, live_chunks[$urandom_range(0, live_chunks.size() - 1)].addr);
            else
                drain_class(c);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_memory_exhaustion();
        int start;
        int oom_seen;
        int oom_prior;
        int c;
        start    = sent_count;
        oom_seen = 0;
        while (oom_seen < 3 && sent_count - start < 300)
        begin
            c = $urandom_range(1, scfla_pkg::NUM_CLASSES_DEF - 1);
            if (class_head[c][16])
            begin
                oom_prior = no_memory_count;
                do_alloc(c);
                if (no_memory_count > oom_prior)
                    oom_seen++;
            end
            else
                drain_class(c);
        end
    endtask

    // response side: random stalls plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (steady_flow || $urandom_range(0, 99) < 75)
                rsp_ready <= 1'b1;
            else
            begin
                hold_left = pick_gap() - 1;
                rsp_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        scfla_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected response: address %h status %0d",
                             rsp.chunk_address, rsp.status);
            end
            else
            begin
                want = expected_responses.pop_front();
                if (rsp.chunk_address !== want.chunk_address || rsp.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Mismatch: expected address %h status %0d, got %h status %0d",
                                 want.chunk_address, want.status,
                                 rsp.chunk_address, rsp.status);
                end
            end
        end
    end

    initial
    begin
        for (int c = 0; c < scfla_pkg::NUM_CLASSES_DEF; c++)
            class_head[c] = NULL_LINK;
        carve_ptr = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_backpressure();
        test_random_traffic(1000);
        test_memory_exhaustion();

        req_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d requests: %0d ok, %0d unmanaged, %0d out of memory",
                 sent_count, ok_count, not_managed_count, no_memory_count);
        $display("%0d blocks carved, %0d of %0d words taken by size classes",
                 blocks_carved, carve_ptr, scfla_pkg::MEM_WORDS_DEF);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/scfla_pkg.sv
design/scfla_ram.sv
design/size_class_free_list_allocator_core.sv
design/scfla_checker.sv
sim/tb_size_class_free_list_allocator_core.sv
